>>> sv/nks_pkg.sv
package nks_pkg;

	localparam int NeighborsDef   = 8;
	localparam int MaxStationsDef = 1024;

	localparam int CountW = 11;
	localparam int SlotW  = 10;
	localparam int LatW   = 20;
	localparam int LonW   = 21;
	localparam int RankW  = 6;
	localparam int IdxW   = 10;
	localparam int DistW  = 42;

	// cosine table: index is |lat_a + lat_b| >> 9, so 0 .. 2048
	localparam int CosW     = 15;
	localparam int CosDepth = 2049;
	localparam int CosAddrW = 12;

	localparam logic [DistW-1:0] DistMax   = '1;
	localparam logic [22:0]      AngleStep = 23'd4670777;
	localparam logic [CosW-1:0]  CosSat    = '1;

	typedef enum logic [0:0] {
		CmdLoad  = 1'b0,
		CmdQuery = 1'b1
	} command_t;

	typedef struct packed {
		logic load;
		logic query;
		logic walk;
		logic emit;
	} nks_cmd_t;

	typedef struct packed {
		logic walk_done;
		logic emit_done;
	} nks_stat_t;

	typedef struct packed {
		logic                we;
		logic [CosAddrW-1:0] addr;
		logic [CosW-1:0]     data;
	} cos_wr_t;

	// Taylor series divisor (2k-1)(2k) for term k, split as 2^pre * odd.
	// The odd part is divided by multiplying with ceil(2^post / odd), exact
	// for dividends below 2^31.
	function automatic logic [1:0] series_pre(input logic [2:0] k);
		logic [1:0] s;
		case (k)
			3'd1:    s = 2'd1;
			3'd2:    s = 2'd2;
			3'd3:    s = 2'd1;
			3'd4:    s = 2'd3;
			3'd5:    s = 2'd1;
			3'd6:    s = 2'd2;
			3'd7:    s = 2'd1;
			default: s = 2'd0;
		endcase
		return s;
	endfunction

	function automatic logic [31:0] series_recip(input logic [2:0] k);
		logic [31:0] m;
		case (k)
			3'd1:    m = 32'd2147483648;
			3'd2:    m = 32'd2863311531;
			3'd3:    m = 32'd2290649225;
			3'd4:    m = 32'd2454267027;
			3'd5:    m = 32'd3054198967;
			3'd6:    m = 32'd4164816772;
			3'd7:    m = 32'd3020636341;
			default: m = 32'd2147483648;
		endcase
		return m;
	endfunction

	function automatic logic [5:0] series_post(input logic [2:0] k);
		logic [5:0] p;
		case (k)
			3'd1:    p = 6'd31;
			3'd2:    p = 6'd33;
			3'd3:    p = 6'd35;
			3'd4:    p = 6'd34;
			3'd5:    p = 6'd37;
			3'd6:    p = 6'd37;
			3'd7:    p = 6'd38;
			default: p = 6'd31;
		endcase
		return p;
	endfunction

endpackage

>>> sv/nearest_k_station_select.sv
// Nearest-station search.
// Input channel (in_valid/in_stall): command 0 loads latitude/longitude into
// store entry station_slot (slots at or above MAX_STATIONS are dropped);
// command 1 is a query point. Loads give no result.
// cfg_we/cfg_wdata sets station_count, the number of entries a query scans.
// A query scans entries 0..count-1 one per cycle through the station memory
// read port and a five-stage distance pipeline, then sends NEIGHBORS result
// items, nearest first, one per cycle while out_stall is low; empty ranks
// have filled low. One item is worked on at a time; in_stall is high while
// busy. After reset a series unit builds the cosine memory over 2049 entries;
// in_stall stays high meanwhile. A stalled result holds in the output
// register; the next rank waits for it.
module nearest_k_station_select #(
	parameter int NEIGHBORS    = nks_pkg::NeighborsDef,
	parameter int MAX_STATIONS = nks_pkg::MaxStationsDef
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [nks_pkg::CountW-1:0]       cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             command,
	input  logic [nks_pkg::SlotW-1:0]        station_slot,
	input  logic signed [nks_pkg::LatW-1:0]  latitude,
	input  logic signed [nks_pkg::LonW-1:0]  longitude,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [nks_pkg::RankW-1:0]        rank,
	output logic [nks_pkg::IdxW-1:0]         station_index,
	output logic                             filled,
	output logic [nks_pkg::DistW-1:0]        distance_sq,
	output logic                             last
);

	nks_pkg::nks_cmd_t  cmd;
	nks_pkg::nks_stat_t stat;
	nks_pkg::cos_wr_t   cos_wr;
	logic               fill_done;

	nks_cosgen u_cosgen (
		.clk       (clk),
		.arst_n    (arst_n),
		.cos_wr    (cos_wr),
		.fill_done (fill_done)
	);

	nks_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.fill_done (fill_done),
		.in_valid  (in_valid),
		.command   (command),
		.stat      (stat),
		.in_stall  (in_stall),
		.cmd       (cmd)
	);

	nks_datapath #(
		.Neighbors   (NEIGHBORS),
		.MaxStations (MAX_STATIONS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.cos_wr        (cos_wr),
		.station_slot  (station_slot),
		.latitude      (latitude),
		.longitude     (longitude),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.rank          (rank),
		.station_index (station_index),
		.filled        (filled),
		.distance_sq   (distance_sq),
		.last          (last)
	);

	a_no_item_before_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> fill_done)
		else $error("item accepted before cosine table was built");

	a_no_result_before_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fill_done)
		else $error("result while cosine table still building");

	a_empty_rank_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !filled |-> distance_sq == nks_pkg::DistMax && station_index == '0)
		else $error("empty rank carries a distance or station");

	a_ranks_run_on: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid)
		else $error("gap inside a query result run");

endmodule

>>> sv/nks_ram.sv
module nks_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
	input  logic [Width-1:0]                         wdata,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
	output logic [Width-1:0]                         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> sv/nks_cosgen.sv
module nks_cosgen (
	input  logic              clk,
	input  logic              arst_n,
	output nks_pkg::cos_wr_t  cos_wr,
	output logic              fill_done
);

	typedef enum logic [6:0] {
		GenX    = 7'b0000001,
		GenX2   = 7'b0000010,
		GenMul  = 7'b0000100,
		GenDiv  = 7'b0001000,
		GenAcc  = 7'b0010000,
		GenWr   = 7'b0100000,
		GenDone = 7'b1000000
	} gen_state_t;

	gen_state_t                      state_q;
	logic [nks_pkg::CosAddrW-1:0]    idx_q;
	logic [29:0]                     x_q;
	logic [31:0]                     x2_q;
	logic [30:0]                     term_q;
	logic signed [33:0]              sum_q;
	logic [2:0]                      k_q;
	logic [34:0]                     quo_q;

	logic [34:0] xa;
	logic [60:0] xx;
	logic [62:0] pp;
	logic [1:0]  pre;
	logic [31:0] recip;
	logic [5:0]  post;
	logic [30:0] num;
	logic [62:0] qprod;
	logic [33:0] sum_mag;
	logic [33:0] rnd;

	always_comb begin
		xa      = 35'(idx_q) * 35'(nks_pkg::AngleStep) + 35'd8;
		xx      = 61'(x_q) * 61'(x_q) + (61'd1 << 27);
		pp      = 63'(term_q) * 63'(x2_q);
		pre     = nks_pkg::series_pre(k_q);
		recip   = nks_pkg::series_recip(k_q);
		post    = nks_pkg::series_post(k_q);
		num     = 31'(quo_q >> pre);
		qprod   = 63'(num) * 63'(recip);
		sum_mag = sum_q[33] ? 34'(-sum_q) : 34'(sum_q);
		rnd     = (sum_mag + 34'd4096) >> 13;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= GenX;
			idx_q   <= '0;
			k_q     <= 3'd1;
		end else begin
			case (state_q)
				GenX: begin
					state_q <= GenX2;
				end
				GenX2: begin
					k_q     <= 3'd1;
					state_q <= GenMul;
				end
				GenMul: begin
					state_q <= GenDiv;
				end
				GenDiv: begin
					state_q <= GenAcc;
				end
				GenAcc: begin
					if (k_q == 3'd7) begin
						state_q <= GenWr;
					end else begin
						k_q     <= k_q + 3'd1;
						state_q <= GenMul;
					end
				end
				GenWr: begin
					if (32'(idx_q) == nks_pkg::CosDepth - 1) begin
						state_q <= GenDone;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= GenX;
					end
				end
				GenDone: begin
					state_q <= GenDone;
				end
				default: begin
					state_q <= GenX;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			GenX: begin
				x_q <= xa[33:4];
			end
			GenX2: begin
				x2_q   <= xx[59:28];
				term_q <= 31'd1 << 28;
				sum_q  <= 34'sd1 <<< 28;
			end
			GenMul: begin
				quo_q <= pp[62:28];
			end
			GenDiv: begin
				quo_q <= 35'(qprod >> post);
			end
			GenAcc: begin
				term_q <= quo_q[30:0];
				if (k_q[0]) begin
					sum_q <= sum_q - $signed(34'(quo_q[30:0]));
				end else begin
					sum_q <= sum_q + $signed(34'(quo_q[30:0]));
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		cos_wr.we   = (state_q == GenWr);
		cos_wr.addr = idx_q;
		cos_wr.data = (rnd > 34'(nks_pkg::CosSat)) ? nks_pkg::CosSat : rnd[nks_pkg::CosW-1:0];
	end

	assign fill_done = (state_q == GenDone);

endmodule

>>> sv/nks_ctrl.sv
module nks_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fill_done,
	input  logic                in_valid,
	input  logic                command,
	input  nks_pkg::nks_stat_t  stat,
	output logic                in_stall,
	output nks_pkg::nks_cmd_t   cmd
);

	typedef enum logic [3:0] {
		StFill = 4'b0001,
		StIdle = 4'b0010,
		StWalk = 4'b0100,
		StEmit = 4'b1000
	} ctrl_state_t;

	ctrl_state_t state_q;
	logic        accept;

	assign in_stall = (state_q != StIdle);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		cmd.load  = accept && (command == nks_pkg::CmdLoad);
		cmd.query = accept && (command == nks_pkg::CmdQuery);
		cmd.walk  = (state_q == StWalk);
		cmd.emit  = (state_q == StEmit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StFill;
		end else begin
			case (state_q)
				StFill: if (fill_done) state_q <= StIdle;
				StIdle: if (cmd.query) state_q <= StWalk;
				StWalk: if (stat.walk_done) state_q <= StEmit;
				StEmit: if (stat.emit_done) state_q <= StIdle;
				default: state_q <= StFill;
			endcase
		end
	end

endmodule

>>> sv/nks_datapath.sv
module nks_datapath #(
	parameter int Neighbors   = nks_pkg::NeighborsDef,
	parameter int MaxStations = nks_pkg::MaxStationsDef
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  nks_pkg::nks_cmd_t                  cmd,
	output nks_pkg::nks_stat_t                 stat,
	input  logic                               cfg_we,
	input  logic [nks_pkg::CountW-1:0]         cfg_wdata,
	input  nks_pkg::cos_wr_t                   cos_wr,
	input  logic [nks_pkg::SlotW-1:0]          station_slot,
	input  logic signed [nks_pkg::LatW-1:0]    latitude,
	input  logic signed [nks_pkg::LonW-1:0]    longitude,
	input  logic                               out_stall,
	output logic                               out_valid,
	output logic [nks_pkg::RankW-1:0]          rank,
	output logic [nks_pkg::IdxW-1:0]           station_index,
	output logic                               filled,
	output logic [nks_pkg::DistW-1:0]          distance_sq,
	output logic                               last
);

	localparam int AddrW  = (MaxStations > 1) ? $clog2(MaxStations) : 1;
	localparam int CntW   = $clog2(MaxStations + 1);
	localparam int SelW   = (Neighbors > 1) ? $clog2(Neighbors) : 1;
	localparam int EmitW  = $clog2(Neighbors + 1);
	localparam int LatW   = nks_pkg::LatW;
	localparam int LonW   = nks_pkg::LonW;
	localparam int DistW  = nks_pkg::DistW;
	localparam int CosW   = nks_pkg::CosW;
	localparam int StW    = LatW + LonW;

	// configuration and query point
	logic [nks_pkg::CountW-1:0] count_q;
	logic signed [LatW-1:0]     pt_lat_q;
	logic signed [LonW-1:0]     pt_lon_q;
	logic [CntW-1:0]            n_lim;
	logic [CntW-1:0]            cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.query) begin
			pt_lat_q <= latitude;
			pt_lon_q <= longitude;
		end
	end

	always_comb begin
		if (32'(count_q) > MaxStations) n_lim = CntW'(MaxStations);
		else n_lim = CntW'(count_q);
	end

	// station store, lat in the upper bits
	logic             st_we;
	logic [StW-1:0]   st_rdata;
	logic             issue;

	assign st_we = cmd.load && (32'(station_slot) < MaxStations);
	assign issue = cmd.walk && (cnt_q != n_lim);

	nks_ram #(.Width(StW), .Depth(MaxStations)) u_station_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (AddrW'(station_slot)),
		.wdata ({latitude, longitude}),
		.raddr (cnt_q[AddrW-1:0]),
		.rdata (st_rdata)
	);

	// distance pipeline
	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [AddrW-1:0]   sidx_s1, sidx_s2, sidx_s3, sidx_s4, sidx_s5;
	logic [LatW:0]      dlat_s2;
	logic [LonW:0]      dlon_s2;
	logic [2*LatW+1:0]  dlsq_s3, dlsq_s4;
	logic [LonW+CosW:0] prod_s3;
	logic [2*LonW+1:0]  dnsq_s4;
	logic [DistW-1:0]   d_s5;

	logic signed [LatW-1:0] slat;
	logic signed [LonW-1:0] slon;
	logic signed [LatW:0]   lsum, ldif;
	logic signed [LonW:0]   ndif;
	logic [LatW:0]          lsum_mag;
	logic [CosW-1:0]        cos_rdata;
	logic [LonW+CosW+1:0]   prod_rnd;
	logic [LonW:0]          dn;
	logic [2*LonW+2:0]      dsum;

	always_comb begin
		slat     = st_rdata[StW-1:LonW];
		slon     = st_rdata[LonW-1:0];
		lsum     = {pt_lat_q[LatW-1], pt_lat_q} + {slat[LatW-1], slat};
		ldif     = {pt_lat_q[LatW-1], pt_lat_q} - {slat[LatW-1], slat};
		ndif     = {pt_lon_q[LonW-1], pt_lon_q} - {slon[LonW-1], slon};
		lsum_mag = lsum[LatW] ? (LatW+1)'(-lsum) : (LatW+1)'(lsum);
		prod_rnd = (LonW+CosW+2)'(prod_s3) + (LonW+CosW+2)'(16384);
		dn       = prod_rnd[LonW+CosW:15];
		dsum     = (2*LonW+3)'(dlsq_s4) + (2*LonW+3)'(dnsq_s4);
	end

	nks_ram #(.Width(CosW), .Depth(nks_pkg::CosDepth)) u_cos_ram (
		.clk   (clk),
		.we    (cos_wr.we),
		.waddr (cos_wr.addr),
		.wdata (cos_wr.data),
		.raddr (lsum_mag[LatW:9]),
		.rdata (cos_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			cnt_q <= '0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			if (cmd.query) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		sidx_s1 <= cnt_q[AddrW-1:0];
		sidx_s2 <= sidx_s1;
		sidx_s3 <= sidx_s2;
		sidx_s4 <= sidx_s3;
		sidx_s5 <= sidx_s4;
		dlat_s2 <= ldif[LatW] ? (LatW+1)'(-ldif) : (LatW+1)'(ldif);
		dlon_s2 <= ndif[LonW] ? (LonW+1)'(-ndif) : (LonW+1)'(ndif);
		dlsq_s3 <= (2*LatW+2)'(dlat_s2) * (2*LatW+2)'(dlat_s2);
		prod_s3 <= (LonW+CosW+1)'(dlon_s2) * (LonW+CosW+1)'(cos_rdata);
		dlsq_s4 <= dlsq_s3;
		dnsq_s4 <= (2*LonW+2)'(dn) * (2*LonW+2)'(dn);
		d_s5    <= (dsum > (2*LonW+3)'(nks_pkg::DistMax)) ? nks_pkg::DistMax
		                                                  : dsum[DistW-1:0];
	end

	// sorted list; lt is false on a prefix and true on the rest
	logic [DistW-1:0] best_dist_q [Neighbors];
	logic [AddrW-1:0] best_st_q   [Neighbors];
	logic             best_fill_q [Neighbors];
	logic [Neighbors-1:0] lt;

	always_comb begin
		for (int l = 0; l < Neighbors; l++) begin
			lt[l] = !best_fill_q[l] || (d_s5 < best_dist_q[l]);
		end
	end

	for (genvar l = 0; l < Neighbors; l++) begin : g_slot
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				best_dist_q[l] <= nks_pkg::DistMax;
				best_st_q[l]   <= '0;
				best_fill_q[l] <= 1'b0;
			end else if (cmd.query) begin
				best_dist_q[l] <= nks_pkg::DistMax;
				best_st_q[l]   <= '0;
				best_fill_q[l] <= 1'b0;
			end else if (v_s5) begin
				if (l > 0 && lt[(l > 0) ? l - 1 : 0]) begin
					best_dist_q[l] <= best_dist_q[(l > 0) ? l - 1 : 0];
					best_st_q[l]   <= best_st_q[(l > 0) ? l - 1 : 0];
					best_fill_q[l] <= best_fill_q[(l > 0) ? l - 1 : 0];
				end else if (lt[l]) begin
					best_dist_q[l] <= d_s5;
					best_st_q[l]   <= sidx_s5;
					best_fill_q[l] <= 1'b1;
				end
			end
		end
	end

	// result emission through the output register
	logic [EmitW-1:0] emit_q;
	logic             out_load;
	logic [SelW-1:0]  sel;

	assign sel      = emit_q[SelW-1:0];
	assign out_load = cmd.emit && (32'(emit_q) < Neighbors) && (!out_valid || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.query) begin
				emit_q <= '0;
			end else if (out_load) begin
				emit_q <= emit_q + 1'b1;
			end
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rank          <= nks_pkg::RankW'(emit_q);
			filled        <= best_fill_q[sel];
			station_index <= best_fill_q[sel] ? nks_pkg::IdxW'(best_st_q[sel]) : '0;
			distance_sq   <= best_fill_q[sel] ? best_dist_q[sel] : nks_pkg::DistMax;
			last          <= (32'(emit_q) == Neighbors - 1);
		end
	end

	always_comb begin
		stat.walk_done = (cnt_q == n_lim) && !(v_s1 || v_s2 || v_s3 || v_s4 || v_s5);
		stat.emit_done = (32'(emit_q) == Neighbors);
	end

endmodule

>>> tb/sv/nearest_k_station_select_tb.sv
`timescale 1ns / 100ps

module nearest_k_station_select_tb;

	localparam int Neighbors   = nks_pkg::NeighborsDef;
	localparam int MaxStations = nks_pkg::MaxStationsDef;
	localparam int LatMax      = 368640;
	localparam int LonMax      = 737280;
	localparam int StallLimit  = 250000;

	typedef struct {
		logic [nks_pkg::RankW-1:0] rank_v;
		logic [nks_pkg::IdxW-1:0]  idx_v;
		logic                      filled_v;
		logic [nks_pkg::DistW-1:0] dist_v;
		logic                      last_v;
	} rank_entry_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [nks_pkg::CountW-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic command = 1'b0;
	logic [nks_pkg::SlotW-1:0] station_slot = '0;
	logic signed [nks_pkg::LatW-1:0] latitude = '0;
	logic signed [nks_pkg::LonW-1:0] longitude = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [nks_pkg::RankW-1:0] rank;
	logic [nks_pkg::IdxW-1:0] station_index;
	logic filled;
	logic [nks_pkg::DistW-1:0] distance_sq;
	logic last;

	// own copy of block state
	int stn_lat [MaxStations];
	int stn_lon [MaxStations];
	int scan_count = 0;
	int loaded_prefix = 0;
	bit written [MaxStations];
	longint unsigned cos_table [nks_pkg::CosDepth];

	rank_entry_t pending_ranks[$];
	int errors = 0;
	int idle_cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	always #1 clk = ~clk;

	nearest_k_station_select dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .command(command),
		.station_slot(station_slot), .latitude(latitude), .longitude(longitude),
		.out_valid(out_valid), .out_stall(out_stall), .rank(rank),
		.station_index(station_index), .filled(filled), .distance_sq(distance_sq),
		.last(last)
	);

	// Q0.15 |cos| of (idx/16 deg * 0.0174) via truncated Taylor series
	function automatic longint unsigned cos_entry(input longint unsigned idx);
		longint unsigned x, x2, term, r;
		longint sum;
		x = (idx * 64'd4670777 + 64'd8) >> 4;
		x2 = (x * x + (64'd1 << 27)) >> 28;
		term = 64'd1 << 28;
		sum = longint'(term);
		for (int k = 1; k <= 7; k++) begin
			term = ((term * x2) >> 28) / longint'((2 * k - 1) * (2 * k));
			if (k % 2 == 1) sum -= longint'(term);
			else sum += longint'(term);
		end
		if (sum < 0) sum = -sum;
		r = (longint'(sum) + 4096) >> 13;
		return (r > 32767) ? 64'd32767 : r;
	endfunction

	function automatic longint unsigned absl(input longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	task automatic predict_nearest(input int plat, input int plon);
		longint unsigned best_d [Neighbors];
		int best_s [Neighbors];
		bit best_f [Neighbors];
		longint unsigned c, dl, dn, d;
		int n;
		rank_entry_t e;
		for (int l = 0; l < Neighbors; l++) begin
			best_d[l] = nks_pkg::DistMax;
			best_s[l] = 0;
			best_f[l] = 0;
		end
		n = (scan_count > MaxStations) ? MaxStations : scan_count;
		for (int m = 0; m < n; m++) begin
			c = cos_table[absl(longint'(plat) + stn_lat[m]) >> 9];
			dl = absl(longint'(plat) - stn_lat[m]);
			dn = (absl(longint'(plon) - stn_lon[m]) * c + 16384) >> 15;
			d = dl * dl + dn * dn;
			if (d > nks_pkg::DistMax) d = nks_pkg::DistMax;
			for (int l = 0; l < Neighbors; l++) begin
				if (!best_f[l] || d < best_d[l]) begin
					for (int h = Neighbors - 1; h > l; h--) begin
						best_d[h] = best_d[h-1];
						best_s[h] = best_s[h-1];
						best_f[h] = best_f[h-1];
					end
					best_d[l] = d;
					best_s[l] = m;
					best_f[l] = 1;
					break;
				end
			end
		end
		for (int l = 0; l < Neighbors; l++) begin
			e.rank_v = nks_pkg::RankW'(l);
			e.idx_v = best_f[l] ? nks_pkg::IdxW'(best_s[l]) : '0;
			e.filled_v = best_f[l];
			e.dist_v = best_f[l] ? nks_pkg::DistW'(best_d[l]) : nks_pkg::DistMax;
			e.last_v = (l == Neighbors - 1);
			pending_ranks.push_back(e);
		end
	endtask

	task automatic send_item(input nks_pkg::command_t cmd, input int slot, input int lat,
		input int lon);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		command = cmd;
		station_slot = nks_pkg::SlotW'(slot);
		latitude = nks_pkg::LatW'(lat);
		longitude = nks_pkg::LonW'(lon);
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		if (cmd == nks_pkg::CmdLoad) begin
			stn_lat[slot] = lat;
			stn_lon[slot] = lon;
			written[slot] = 1;
			while (loaded_prefix < MaxStations && written[loaded_prefix])
				loaded_prefix++;
		end else begin
			predict_nearest(lat, lon);
		end
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_ranks.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_count(input int v);
		wait_drained();
		cfg_wdata = nks_pkg::CountW'(v);
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		scan_count = v;
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		rank_entry_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_ranks.size() == 0) begin
				report_mismatch("unexpected item rank", rank, -1);
			end else begin
				e = pending_ranks.pop_front();
				if (rank !== e.rank_v) report_mismatch("rank", rank, e.rank_v);
				if (station_index !== e.idx_v)
					report_mismatch("station_index", station_index, e.idx_v);
				if (filled !== e.filled_v) report_mismatch("filled", filled, e.filled_v);
				if (distance_sq !== e.dist_v)
					report_mismatch("distance_sq", distance_sq, e.dist_v);
				if (last !== e.last_v) report_mismatch("last", last, e.last_v);
			end
		end
	end

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	// cosine build after reset is covered by the limit
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= StallLimit) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic int rand_lat();
		return $urandom_range(2 * LatMax) - LatMax;
	endfunction

	function automatic int rand_lon();
		return $urandom_range(2 * LonMax) - LonMax;
	endfunction

	task automatic test_empty_store();
		write_count(0);
		send_item(nks_pkg::CmdQuery, 0, 0, 0);
		send_item(nks_pkg::CmdQuery, 1023, LatMax, -LonMax);
	endtask

	task automatic test_directed();
		send_item(nks_pkg::CmdLoad, 0, LatMax, LonMax);
		send_item(nks_pkg::CmdLoad, 1, -LatMax, -LonMax);
		send_item(nks_pkg::CmdLoad, 2, 0, 0);
		send_item(nks_pkg::CmdLoad, 3, 100, -200);
		send_item(nks_pkg::CmdLoad, 4, 100, -200);   // tie with previous station
		send_item(nks_pkg::CmdLoad, 5, -LatMax, LonMax);
		send_item(nks_pkg::CmdLoad, 6, LatMax, -LonMax);
		send_item(nks_pkg::CmdLoad, 7, 4096, 4096);
		send_item(nks_pkg::CmdLoad, 8, -1, 1);
		send_item(nks_pkg::CmdLoad, 9, 100, -200);
		write_count(10);
		send_item(nks_pkg::CmdQuery, 0, 100, -200);
		send_item(nks_pkg::CmdQuery, 0, LatMax, LonMax);
		send_item(nks_pkg::CmdQuery, 0, -LatMax, -LonMax);
		send_item(nks_pkg::CmdQuery, 0, LatMax, -LonMax);
		send_item(nks_pkg::CmdQuery, 0, 0, 0);
		write_count(3);
		send_item(nks_pkg::CmdQuery, 0, -LatMax, LonMax);
		write_count(1);
		send_item(nks_pkg::CmdQuery, 0, 7, 7);
	endtask

	task automatic test_random_phase(input int idle_pct, input int stall_pct, input int items);
		int slot, lat, lon, base;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < items; i++) begin
			if (i % 20 == 0)
				write_count($urandom_range(loaded_prefix < 48 ? loaded_prefix : 48));
			if ($urandom_range(99) < 55) begin
				slot = $urandom_range(loaded_prefix < 60 ? loaded_prefix : 60);
				send_item(nks_pkg::CmdLoad, slot, rand_lat(), rand_lon());
			end else begin
				if ($urandom_range(3) == 0) begin
					lat = rand_lat();
					lon = rand_lon();
				end else begin
					// near a loaded station so rankings are tight
					base = $urandom_range(scan_count > 0 ? scan_count - 1 : 0);
					lat = stn_lat[base] + int'($urandom_range(8000)) - 4000;
					lon = stn_lon[base] + int'($urandom_range(8000)) - 4000;
					if (lat > LatMax) lat = LatMax;
					if (lat < -LatMax) lat = -LatMax;
					if (lon > LonMax) lon = LonMax;
					if (lon < -LonMax) lon = -LonMax;
				end
				send_item(nks_pkg::CmdQuery, 0, lat, lon);
			end
		end
	endtask

	task automatic test_wide_scan();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int s = 0; s < 44; s++)
			send_item(nks_pkg::CmdLoad, s, rand_lat(), rand_lon());
		send_item(nks_pkg::CmdLoad, MaxStations - 1, LatMax, LonMax);
		write_count(44);
		send_item(nks_pkg::CmdQuery, 0, rand_lat(), rand_lon());
		send_item(nks_pkg::CmdQuery, 0, stn_lat[43], stn_lon[43]);
		recv_stall_pct = 59;
		send_item(nks_pkg::CmdQuery, 0, 0, 0);
		send_item(nks_pkg::CmdQuery, 0, stn_lat[20], stn_lon[20]);
	endtask

	initial begin
		for (int i = 0; i < nks_pkg::CosDepth; i++) cos_table[i] = cos_entry(i);
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_empty_store();
		test_directed();
		test_random_phase(0, 0, 100);
		test_random_phase(59, 0, 100);
		test_random_phase(0, 59, 100);
		test_random_phase(11, 11, 100);
		test_wide_scan();
		wait_drained();
		repeat (40) @(posedge clk);
		if (errors == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

endmodule
